/* rtl/lbcjd_pkg.sv */
// ---------------------------------------------------------------------------
// lbcjd_pkg: shared types and constants of the core job dispatcher
// Holds the command and result words and the codes used by front and back.
// ---------------------------------------------------------------------------
package lbcjd_pkg;

	localparam int CORES       = 4;
	localparam int QUEUE_DEPTH = 4;
	localparam int NGROUPS     = 3;
	localparam int NCORE_ALL   = NGROUPS * CORES;
	localparam int NENT        = NCORE_ALL * QUEUE_DEPTH;

	localparam int CW   = $clog2(NCORE_ALL);
	localparam int LW   = (CORES > 1) ? $clog2(CORES) : 1;
	localparam int NW   = 3;
	localparam int QW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNTW = $clog2(QUEUE_DEPTH + 1);
	localparam int AW   = $clog2(NENT);
	localparam int GW   = 2;

	localparam int FQ_DEPTH = 2;
	localparam int FQ_AW    = 1;

	localparam logic [2:0] NO_CORE = 3'd4;

	localparam logic [1:0] REG_HOST  = 2'd0;
	localparam logic [1:0] REG_CACHE = 2'd1;
	localparam logic [1:0] REG_TRANS = 2'd2;

	typedef enum logic [1:0] {
		OP_SUBMIT  = 2'd0,
		OP_ACCOUNT = 2'd1,
		OP_TICK    = 2'd2,
		OP_CLEAR   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		K_DONE    = 2'd0,
		K_QUEUED  = 2'd1,
		K_LATENCY = 2'd2,
		K_CLEARED = 2'd3
	} kind_t;

	typedef struct packed {
		op_t          op;
		logic [1:0]   grp;
		logic [NW-1:0] ncores;
		logic [31:0]  lat;
		logic [31:0]  dly;
		logic [15:0]  tag;
	} cmd_t;

	typedef struct packed {
		kind_t        kind;
		logic [1:0]   grp;
		logic [2:0]   core;
		logic [15:0]  tag;
		logic [31:0]  lat;
		logic [63:0]  etime;
		logic         status;
		logic         last;
	} res_t;

	typedef struct packed {
		logic [15:0] tag;
		logic [31:0] lat;
		logic [31:0] dly;
		logic [63:0] sub;
	} ent_t;

endpackage

/* rtl/lbcjd_front.sv */
// ---------------------------------------------------------------------------
// lbcjd_front: request intake
// Classifies each request word by group core count and queues it for the back.
// ---------------------------------------------------------------------------
module lbcjd_front import lbcjd_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   req_valid,
	output logic                   req_ready,
	input  logic [1:0]             operation,
	input  logic [1:0]             group,
	input  logic [31:0]            job_latency,
	input  logic [31:0]            start_delay,
	input  logic [15:0]            job_tag,
	input  logic [NGROUPS-1:0][2:0] cfg_cores,
	output logic                   cmd_valid,
	output cmd_t                   cmd,
	input  logic                   cmd_pop
);

	cmd_t              fifo_q [FQ_DEPTH];
	logic [FQ_AW-1:0]  wp_q;
	logic [FQ_AW-1:0]  rp_q;
	logic [FQ_AW:0]    cnt_q;
	logic [2:0]        raw_n;
	logic [NW-1:0]     n_sat;
	cmd_t              in_cmd;
	logic              push;
	logic              pop;

	// clamp the group's core count; unknown group has no cores
	always_comb begin
		case (group)
			REG_HOST:  raw_n = cfg_cores[0];
			REG_CACHE: raw_n = cfg_cores[1];
			REG_TRANS: raw_n = cfg_cores[2];
			default:   raw_n = 3'd0;
		endcase
		n_sat = (raw_n > 3'(CORES)) ? NW'(CORES) : NW'(raw_n);
	end

	assign in_cmd = '{op: op_t'(operation), grp: group, ncores: n_sat,
		lat: job_latency, dly: start_delay, tag: job_tag};

	assign req_ready = (cnt_q != (FQ_AW + 1)'(FQ_DEPTH));
	assign push      = req_valid && req_ready;
	assign cmd_valid = (cnt_q != '0);
	assign pop       = cmd_pop && cmd_valid;
	assign cmd       = fifo_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + 1'b1;
			if (pop) rp_q <= rp_q + 1'b1;
			if (push && !pop) cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) fifo_q[wp_q] <= in_cmd;
	end

endmodule

/* rtl/lbcjd_back.sv */
// ---------------------------------------------------------------------------
// lbcjd_back: dispatch engine
// Picks cores, keeps per-core queues and timing, and retires jobs on ticks.
// ---------------------------------------------------------------------------
module lbcjd_back import lbcjd_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	input  cmd_t cmd,
	output logic cmd_pop,
	output logic res_valid,
	output res_t res,
	input  logic res_ready
);

	typedef enum logic [8:0] {
		S_IDLE  = 9'b000000001,
		S_PICK  = 9'b000000010,
		S_PICK2 = 9'b000000100,
		S_ACT   = 9'b000001000,
		S_CHK   = 9'b000010000,
		S_RET   = 9'b000100000,
		S_ST1   = 9'b001000000,
		S_ST2   = 9'b010000000,
		S_FLUSH = 9'b100000000
	} state_t;

	state_t             state_q;
	logic [63:0]        time_q;
	logic [NCORE_ALL-1:0] active_q;
	logic [63:0]        busy_q [NCORE_ALL];
	logic [63:0]        fin_q  [NCORE_ALL];
	logic [CNTW-1:0]    cnt_q  [NCORE_ALL];
	logic [QW-1:0]      head_q [NCORE_ALL];
	cmd_t               cmd_q;
	logic [LW-1:0]      scan_i_q;
	logic [LW-1:0]      sel_q;
	logic               found_q;
	logic [63:0]        best_q;
	logic [CNTW-1:0]    qmin_q;
	logic [GW-1:0]      tg_q;
	logic [LW-1:0]      ti_q;
	res_t               pend_q;
	logic               pend_v_q;
	logic [64:0]        st_q;
	logic [31:0]        lat_q;
	ent_t               mem_q [NENT];
	ent_t               rd_q;

	logic [CW-1:0]      base;
	logic [CW-1:0]      ci;
	logic               a_c;
	logic [63:0]        b_c;
	logic [63:0]        f_c;
	logic [CNTW-1:0]    cn;
	logic [QW-1:0]      hd;
	logic [QW-1:0]      hnext;
	logic [CNTW:0]      tsum;
	logic [QW-1:0]      tslot;
	logic               scan_last;
	logic               full;
	logic               due;
	logic               put_block;
	logic [32:0]        sum33;
	logic [64:0]        t65;
	logic [63:0]        fin_new;
	logic [64:0]        sd;
	logic [64:0]        st_next;
	logic [65:0]        f66;
	logic [63:0]        fin2;
	logic               mem_we;
	logic               mem_re;
	logic [AW-1:0]      wa;
	logic [AW-1:0]      ra;
	ent_t               wd;

	assign base = CW'(cmd_q.grp) * CW'(CORES);

	always_comb begin
		case (state_q)
			S_PICK, S_PICK2: ci = base + CW'(scan_i_q);
			S_ACT:           ci = base + CW'(sel_q);
			default:         ci = CW'(tg_q) * CW'(CORES) + CW'(ti_q);
		endcase
	end

	assign a_c   = active_q[ci];
	assign b_c   = busy_q[ci];
	assign f_c   = fin_q[ci];
	assign cn    = cnt_q[ci];
	assign hd    = head_q[ci];
	assign hnext = (hd == QW'(QUEUE_DEPTH - 1)) ? '0 : hd + 1'b1;
	assign tsum  = (CNTW + 1)'(hd) + (CNTW + 1)'(cn);
	assign tslot = (tsum >= (CNTW + 1)'(QUEUE_DEPTH)) ?
		QW'(tsum - (CNTW + 1)'(QUEUE_DEPTH)) : QW'(tsum);

	assign scan_last = (NW'(scan_i_q) == cmd_q.ncores - NW'(1));
	assign full      = (cn >= CNTW'(QUEUE_DEPTH));
	assign due       = a_c && (cn != '0) && (f_c <= time_q);
	assign put_block = pend_v_q && !res_ready;

	// finish time of a job that starts at once on submit
	assign sum33   = {1'b0, cmd_q.lat} + {1'b0, cmd_q.dly};
	assign t65     = {1'b0, time_q} + 65'(sum33);
	assign fin_new = t65[64] ? '1 : t65[63:0];

	// start of a chained job: the later of now and submit plus delay
	assign sd      = {1'b0, rd_q.sub} + 65'(rd_q.dly);
	assign st_next = (sd > {1'b0, time_q}) ? sd : {1'b0, time_q};
	assign f66     = {1'b0, st_q} + 66'(lat_q);
	assign fin2    = (f66[65:64] != 2'b00) ? '1 : f66[63:0];

	assign cmd_pop   = (state_q == S_IDLE) && cmd_valid;
	assign res_valid = pend_v_q && ((state_q == S_RET) || (state_q == S_FLUSH));
	always_comb begin
		res      = pend_q;
		res.last = (state_q == S_FLUSH);
	end

	assign mem_we = (state_q == S_ACT) && (cmd_q.op == OP_SUBMIT) && !full;
	assign wa     = AW'(ci) * AW'(QUEUE_DEPTH) + AW'(tslot);
	assign wd     = '{tag: cmd_q.tag, lat: cmd_q.lat, dly: cmd_q.dly, sub: time_q};

	always_comb begin
		mem_re = 1'b0;
		ra     = AW'(ci) * AW'(QUEUE_DEPTH) + AW'(hd);
		if (state_q == S_CHK && tg_q != GW'(NGROUPS) && due) begin
			mem_re = 1'b1;
		end else if (state_q == S_RET && !put_block && cn > CNTW'(1)) begin
			mem_re = 1'b1;
			ra     = AW'(ci) * AW'(QUEUE_DEPTH) + AW'(hnext);
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem_q[wa] <= wd;
		if (mem_re) rd_q <= mem_q[ra];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			time_q   <= '0;
			active_q <= '0;
			for (int k = 0; k < NCORE_ALL; k++) begin
				busy_q[k] <= '0;
				fin_q[k]  <= '0;
				cnt_q[k]  <= '0;
				head_q[k] <= '0;
			end
			cmd_q    <= '0;
			scan_i_q <= '0;
			sel_q    <= '0;
			found_q  <= 1'b0;
			best_q   <= '0;
			qmin_q   <= '0;
			tg_q     <= '0;
			ti_q     <= '0;
			pend_q   <= '0;
			pend_v_q <= 1'b0;
			st_q     <= '0;
			lat_q    <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						cmd_q <= cmd;
						case (cmd.op)
							OP_CLEAR: begin
								for (int k = 0; k < NCORE_ALL; k++) busy_q[k] <= '0;
								pend_q <= '{kind: K_CLEARED, grp: '0, core: '0, tag: '0,
									lat: '0, etime: time_q, status: 1'b0, last: 1'b0};
								pend_v_q <= 1'b1;
								state_q  <= S_FLUSH;
							end
							OP_TICK: begin
								time_q  <= time_q + 64'd1;
								tg_q    <= '0;
								ti_q    <= '0;
								state_q <= S_CHK;
							end
							default: begin
								if (cmd.ncores == '0) begin
									pend_q <= '{kind: (cmd.op == OP_SUBMIT) ? K_DONE : K_LATENCY,
										grp: cmd.grp, core: NO_CORE, tag: cmd.tag, lat: '0,
										etime: time_q, status: 1'b0, last: 1'b0};
									pend_v_q <= 1'b1;
									state_q  <= S_FLUSH;
								end else begin
									scan_i_q <= '0;
									found_q  <= 1'b0;
									state_q  <= S_PICK;
								end
							end
						endcase
					end
				end
				S_PICK: begin
					// idle core with the smallest busy total, first on ties
					if (!a_c && (!found_q || b_c < best_q)) begin
						best_q  <= b_c;
						sel_q   <= scan_i_q;
						found_q <= 1'b1;
					end
					if (scan_last) begin
						scan_i_q <= '0;
						state_q  <= (found_q || !a_c) ? S_ACT : S_PICK2;
					end else begin
						scan_i_q <= scan_i_q + 1'b1;
					end
				end
				S_PICK2: begin
					// all busy: fewest queued jobs, last on ties
					if (scan_i_q == '0 || cn <= qmin_q) begin
						qmin_q <= cn;
						sel_q  <= scan_i_q;
					end
					if (scan_last) state_q <= S_ACT;
					else scan_i_q <= scan_i_q + 1'b1;
				end
				S_ACT: begin
					if (cmd_q.op == OP_ACCOUNT) begin
						busy_q[ci] <= b_c + 64'(cmd_q.lat);
						pend_q <= '{kind: K_LATENCY, grp: cmd_q.grp, core: 3'(sel_q),
							tag: cmd_q.tag, lat: cmd_q.lat, etime: time_q,
							status: 1'b0, last: 1'b0};
					end else begin
						if (!full) begin
							cnt_q[ci] <= cn + 1'b1;
							if (!a_c) begin
								fin_q[ci]    <= fin_new;
								active_q[ci] <= 1'b1;
							end
						end
						pend_q <= '{kind: K_QUEUED, grp: cmd_q.grp, core: 3'(sel_q),
							tag: cmd_q.tag, lat: cmd_q.lat, etime: time_q,
							status: full, last: 1'b0};
					end
					pend_v_q <= 1'b1;
					state_q  <= S_FLUSH;
				end
				S_CHK: begin
					if (tg_q == GW'(NGROUPS)) begin
						state_q <= S_FLUSH;
					end else if (due) begin
						state_q <= S_RET;
					end else if (ti_q == LW'(CORES - 1)) begin
						ti_q <= '0;
						tg_q <= tg_q + 1'b1;
					end else begin
						ti_q <= ti_q + 1'b1;
					end
				end
				S_RET: begin
					// hold until the previous result word has left
					if (!put_block) begin
						busy_q[ci] <= b_c + 64'(rd_q.lat);
						pend_q <= '{kind: K_DONE, grp: tg_q, core: 3'(ti_q), tag: rd_q.tag,
							lat: rd_q.lat, etime: time_q, status: 1'b0, last: 1'b0};
						pend_v_q     <= 1'b1;
						head_q[ci]   <= hnext;
						cnt_q[ci]    <= cn - 1'b1;
						active_q[ci] <= 1'b0;
						state_q      <= (cn > CNTW'(1)) ? S_ST1 : S_CHK;
					end
				end
				S_ST1: begin
					st_q    <= st_next;
					lat_q   <= rd_q.lat;
					state_q <= S_ST2;
				end
				S_ST2: begin
					fin_q[ci]    <= fin2;
					active_q[ci] <= 1'b1;
					state_q      <= S_CHK;
				end
				S_FLUSH: begin
					if (!pend_v_q) begin
						state_q <= S_IDLE;
					end else if (res_ready) begin
						pend_v_q <= 1'b0;
						state_q  <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

/* rtl/least_busy_core_job_dispatcher.sv */
// ---------------------------------------------------------------------------
// least_busy_core_job_dispatcher: least-busy core job dispatcher top level
// Timing: a group with no cores answers without a scan; otherwise the engine
//   scans the group one core per cycle, and scans it again when no core is idle.
//   A tick scans all cores one per cycle, stopping to retire each due job;
//   its last word is marked last, and a tick with nothing due gives none.
// Throughput: one request word at a time in the dispatch engine; a two-word
//   command queue and the output register let both sides stall on their own.
// Reset: asynchronous, clears time, core state, busy totals and queue counts;
//   core counts reset to 1. The queue entry memory is not cleared.
// ---------------------------------------------------------------------------
module least_busy_core_job_dispatcher import lbcjd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_ready,
	input  logic [1:0]  operation,
	input  logic [1:0]  group,
	input  logic [31:0] job_latency,
	input  logic [31:0] start_delay,
	input  logic [15:0] job_tag,
	output logic        rsp_valid,
	input  logic        rsp_ready,
	output logic [1:0]  kind,
	output logic [1:0]  group_out,
	output logic [2:0]  core,
	output logic [15:0] tag_out,
	output logic [31:0] latency_out,
	output logic [63:0] event_time,
	output logic        status,
	output logic        last,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [NGROUPS-1:0][2:0] cfg_q;
	logic                    cmd_valid;
	cmd_t                    cmd;
	logic                    cmd_pop;
	logic                    res_valid;
	res_t                    res;
	logic                    out_free;
	logic                    out_valid_q;
	res_t                    out_q;
	logic                    cfg_we;

	// Configuration: three core-count registers, one per word address.
	assign pready = 1'b1;
	assign cfg_we = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= {NGROUPS{3'd1}};
		end else if (cfg_we) begin
			case (paddr[3:2])
				REG_HOST:  cfg_q[0] <= pwdata[2:0];
				REG_CACHE: cfg_q[1] <= pwdata[2:0];
				REG_TRANS: cfg_q[2] <= pwdata[2:0];
				default:   ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_HOST:  prdata = {29'd0, cfg_q[0]};
			REG_CACHE: prdata = {29'd0, cfg_q[1]};
			REG_TRANS: prdata = {29'd0, cfg_q[2]};
			default:   prdata = '0;
		endcase
	end

	// Front: take request words, tag them with the group core count, queue.
	lbcjd_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_ready   (req_ready),
		.operation   (operation),
		.group       (group),
		.job_latency (job_latency),
		.start_delay (start_delay),
		.job_tag     (job_tag),
		.cfg_cores   (cfg_q),
		.cmd_valid   (cmd_valid),
		.cmd         (cmd),
		.cmd_pop     (cmd_pop)
	);

	// Back: pick a core, queue or account the job, retire due jobs on ticks.
	lbcjd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd       (cmd),
		.cmd_pop   (cmd_pop),
		.res_valid (res_valid),
		.res       (res),
		.res_ready (out_free)
	);

	// Output register: load a new result word whenever the slot is empty
	// or being drained this cycle.
	assign out_free = !out_valid_q || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_q       <= '0;
		end else if (out_free) begin
			out_valid_q <= res_valid;
			if (res_valid) out_q <= res;
		end
	end

	assign rsp_valid   = out_valid_q;
	assign kind        = out_q.kind;
	assign group_out   = out_q.grp;
	assign core        = out_q.core;
	assign tag_out     = out_q.tag;
	assign latency_out = out_q.lat;
	assign event_time  = out_q.etime;
	assign status      = out_q.status;
	assign last        = out_q.last;

	// A dropped job always names the core whose queue was full.
	a_full_has_core: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && status) |-> (kind == K_QUEUED && core != NO_CORE))
		else $error("queue-full result without a core");

	// No core available means no latency is reported.
	a_nocore_zero_lat: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && core == NO_CORE) |-> (latency_out == 32'd0))
		else $error("latency reported without a core");

	// A clear produces exactly one result word.
	a_clear_single: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && kind == K_CLEARED) |-> last)
		else $error("clear result not marked last");

endmodule

/* sim/tb.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb: testbench of the least-busy core job dispatcher
// Drives request words with random gaps, predicts every result word from a
// model of the dispatcher kept here, and checks the result stream in order.
// ---------------------------------------------------------------------------
module tb;
	import lbcjd_pkg::*;

	localparam int WDOG_LIMIT = 5000;
	localparam int SETTLE     = 60;

	logic        clk;
	logic        arst_n;
	logic        req_valid;
	logic        req_ready;
	logic [1:0]  operation;
	logic [1:0]  group;
	logic [31:0] job_latency;
	logic [31:0] start_delay;
	logic [15:0] job_tag;
	logic        rsp_valid;
	logic        rsp_ready;
	logic [1:0]  kind;
	logic [1:0]  group_out;
	logic [2:0]  core;
	logic [15:0] tag_out;
	logic [31:0] latency_out;
	logic [63:0] event_time;
	logic        status;
	logic        last;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	least_busy_core_job_dispatcher u_top (.*);

	// dispatcher model state
	logic [63:0] now_ticks;
	bit          core_busy_flag [NCORE_ALL];
	logic [63:0] busy_ticks     [NCORE_ALL];
	logic [63:0] finish_at      [NCORE_ALL];
	int          pending_jobs   [NCORE_ALL];
	int          head_slot      [NCORE_ALL];
	ent_t        job_slots      [NENT];
	int          cores_cfg      [NGROUPS];

	res_t        expected_q [$];
	int          errors;
	int          sender_idle_pct;
	int          receiver_stall_pct;
	int          quiet_cycles;

	// clock and reset
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [63:0] sat_sum(logic [63:0] a, logic [63:0] b);
		logic [64:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[64] ? '1 : s[63:0];
	endfunction

	// pick a core: least busy idle core first, else shortest queue (last on ties)
	function automatic int pick_core(int base, int n);
		int          idx;
		bit          found;
		logic [63:0] best;
		int          qmin;
		idx   = 0;
		found = 0;
		best  = '0;
		qmin  = 0;
		for (int i = 0; i < n; i++) begin
			if (!core_busy_flag[base+i] && (!found || busy_ticks[base+i] < best)) begin
				best  = busy_ticks[base+i];
				idx   = i;
				found = 1;
			end
		end
		if (!found) begin
			for (int i = 0; i < n; i++) begin
				if (i == 0 || pending_jobs[base+i] <= qmin) begin
					qmin = pending_jobs[base+i];
					idx  = i;
				end
			end
		end
		return idx;
	endfunction

	// start the head job of a core; unspent start delay pushes the finish out
	function automatic void start_head(int c);
		int          e;
		logic [63:0] waited;
		logic [63:0] f;
		e      = c*QUEUE_DEPTH + head_slot[c];
		waited = now_ticks - job_slots[e].sub;
		f      = sat_sum(now_ticks, {32'd0, job_slots[e].lat});
		if (waited < {32'd0, job_slots[e].dly})
			f = sat_sum(f, {32'd0, job_slots[e].dly} - waited);
		finish_at[c]      = f;
		core_busy_flag[c] = 1;
	endfunction

	function automatic void push_result(kind_t k, logic [1:0] g, logic [2:0] cr,
			logic [15:0] t, logic [31:0] l, logic st);
		res_t r;
		r.kind   = k;
		r.grp    = g;
		r.core   = cr;
		r.tag    = t;
		r.lat    = l;
		r.etime  = now_ticks;
		r.status = st;
		r.last   = 1'b0;
		expected_q = {expected_q, r};
	endfunction

	// work out the result words of one accepted request word
	function automatic void predict_request(op_t op, logic [1:0] g, logic [31:0] lat,
			logic [31:0] dly, logic [15:0] tag);
		int n, i, c, e, before_cnt;
		before_cnt = expected_q.size();
		n = (g < NGROUPS) ? ((cores_cfg[g] > CORES) ? CORES : cores_cfg[g]) : 0;
		case (op)
			OP_SUBMIT: begin
				if (n == 0) begin
					push_result(K_DONE, g, NO_CORE, tag, '0, 1'b0);
				end else begin
					i = pick_core(g*CORES, n);
					c = g*CORES + i;
					if (pending_jobs[c] >= QUEUE_DEPTH) begin
						push_result(K_QUEUED, g, 3'(i), tag, lat, 1'b1);
					end else begin
						e = c*QUEUE_DEPTH + (head_slot[c] + pending_jobs[c]) % QUEUE_DEPTH;
						job_slots[e].tag = tag;
						job_slots[e].lat = lat;
						job_slots[e].dly = dly;
						job_slots[e].sub = now_ticks;
						pending_jobs[c]++;
						if (!core_busy_flag[c])
							start_head(c);
						push_result(K_QUEUED, g, 3'(i), tag, lat, 1'b0);
					end
				end
			end
			OP_ACCOUNT: begin
				if (n == 0) begin
					push_result(K_LATENCY, g, NO_CORE, tag, '0, 1'b0);
				end else begin
					i = pick_core(g*CORES, n);
					busy_ticks[g*CORES+i] += lat;
					push_result(K_LATENCY, g, 3'(i), tag, lat, 1'b0);
				end
			end
			OP_TICK: begin
				now_ticks += 1;
				// retire due jobs core by core; the next job may finish at once
				for (c = 0; c < NCORE_ALL; c++) begin
					while (core_busy_flag[c] && pending_jobs[c] > 0 && finish_at[c] <= now_ticks) begin
						e = c*QUEUE_DEPTH + head_slot[c];
						busy_ticks[c] += job_slots[e].lat;
						push_result(K_DONE, 2'(c / CORES), 3'(c % CORES), job_slots[e].tag,
							job_slots[e].lat, 1'b0);
						head_slot[c]      = (head_slot[c] + 1) % QUEUE_DEPTH;
						pending_jobs[c]--;
						core_busy_flag[c] = 0;
						if (pending_jobs[c] > 0)
							start_head(c);
					end
				end
			end
			default: begin
				for (c = 0; c < NCORE_ALL; c++)
					busy_ticks[c] = '0;
				push_result(K_CLEARED, '0, '0, '0, '0, 1'b0);
			end
		endcase
		if (expected_q.size() > before_cnt)
			expected_q[expected_q.size()-1].last = 1'b1;
	endfunction

	// send one request word; gaps before it follow the sender idle rate
	task automatic send_word(op_t op, logic [1:0] g, logic [31:0] lat, logic [31:0] dly,
			logic [15:0] tag);
		@(negedge clk);
		while ($urandom_range(99) < sender_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		req_valid   <= 1'b1;
		operation   <= op;
		group       <= g;
		job_latency <= lat;
		start_delay <= dly;
		job_tag     <= tag;
		@(posedge clk);
		while (!req_ready)
			@(posedge clk);
		predict_request(op, g, lat, dly, tag);
	endtask

	task automatic idle_sender();
		@(negedge clk);
		req_valid <= 1'b0;
	endtask

	// wait until every expected word is in, then let a silent tick finish
	task automatic drain();
		idle_sender();
		while (expected_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [31:0] value);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		cores_cfg[idx] = value[2:0];
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic set_cores(int h, int c, int t);
		drain();
		write_reg(REG_HOST, 32'(h));
		write_reg(REG_CACHE, 32'(c));
		write_reg(REG_TRANS, 32'(t));
	endtask

	// groups without cores and the unused group code answer at once
	task automatic test_empty_groups();
		set_cores(0, 0, 0);
		send_word(OP_SUBMIT, 2'd0, 32'hFFFF_FFFF, 32'd0, 16'hFFFF);
		send_word(OP_ACCOUNT, 2'd1, 32'd77, 32'd0, 16'h0000);
		send_word(OP_SUBMIT, 2'd3, 32'd5, 32'd5, 16'h1234);
		send_word(OP_ACCOUNT, 2'd3, 32'd5, 32'd5, 16'h4321);
		send_word(OP_TICK, 2'd2, 32'd0, 32'd0, 16'd0);
	endtask

	// fill one core past its queue depth, then retire with chained ticks
	task automatic test_queue_full();
		set_cores(7, 4, 1);
		for (int k = 0; k < 5; k++)
			send_word(OP_SUBMIT, 2'd2, 32'(k), (k == 0) ? 32'd2 : 32'd0, 16'(k + 'h100));
		repeat (5) send_word(OP_TICK, 2'd0, 32'd0, 32'd0, 16'd0);
	endtask

	// least-busy selection, accounting and clearing
	task automatic test_pick_and_clear();
		send_word(OP_ACCOUNT, 2'd1, 32'd10, 32'd0, 16'hA0);
		send_word(OP_ACCOUNT, 2'd1, 32'd3, 32'd0, 16'hA1);
		send_word(OP_SUBMIT, 2'd1, 32'd1, 32'd0, 16'hA2);
		send_word(OP_SUBMIT, 2'd1, 32'd2, 32'd0, 16'hA3);
		send_word(OP_CLEAR, 2'd2, 32'd9, 32'd9, 16'hBEEF);
		send_word(OP_TICK, 2'd0, 32'd0, 32'd0, 16'd0);
		send_word(OP_TICK, 2'd0, 32'd0, 32'd0, 16'd0);
		// a job with the largest fields parks a translation core for good
		send_word(OP_SUBMIT, 2'd2, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF);
	endtask

	task automatic test_random(int h, int c, int t, int idle_pct, int stall_pct, int items);
		logic [31:0] lat, dly;
		int          pick;
		op_t         op;
		set_cores(h, c, t);
		sender_idle_pct    = idle_pct;
		receiver_stall_pct = stall_pct;
		for (int k = 0; k < items; k++) begin
			pick = $urandom_range(99);
			op   = (pick < 40) ? OP_SUBMIT : (pick < 55) ? OP_ACCOUNT :
				(pick < 95) ? OP_TICK : OP_CLEAR;
			lat  = $urandom_range(5);
			dly  = $urandom_range(6);
			// rarely use full-width values, but for half of the accounts; they keep a core busy forever
			if ($urandom_range(99) < 3 || op == OP_ACCOUNT && $urandom_range(1))
				lat = $urandom;
			if ($urandom_range(99) < 3)
				dly = $urandom;
			send_word(op, ($urandom_range(19) == 0) ? 2'd3 : 2'($urandom_range(2)),
				lat, dly, 16'($urandom));
		end
	endtask

	// receiver stalls at the falling edge
	always @(negedge clk)
		rsp_ready <= ($urandom_range(99) >= receiver_stall_pct);

	task automatic check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
		if (exp_v !== act_v) begin
			$display("%0t mismatch %s: expected %0h actual %0h", $time, name, exp_v, act_v);
			errors++;
		end
	endtask

	// compare every accepted result word with the oldest expectation
	always @(posedge clk) begin
		res_t e;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (expected_q.size() == 0) begin
				$display("%0t unexpected result: kind %0d tag %0h", $time, kind, tag_out);
				errors++;
			end else begin
				e = expected_q.pop_front();
				check_field("kind", e.kind, kind);
				check_field("group_out", e.grp, group_out);
				check_field("core", e.core, core);
				check_field("tag_out", e.tag, tag_out);
				check_field("latency_out", e.lat, latency_out);
				check_field("event_time", e.etime, event_time);
				check_field("status", e.status, status);
				check_field("last", e.last, last);
			end
		end
	end

	// watchdog: count cycles with no word moving on any port
	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || (psel && penable))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == WDOG_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	initial begin
		errors             = 0;
		quiet_cycles       = 0;
		sender_idle_pct    = 0;
		receiver_stall_pct = 0;
		now_ticks          = '0;
		for (int c = 0; c < NCORE_ALL; c++) begin
			core_busy_flag[c] = 0;
			busy_ticks[c]     = '0;
			finish_at[c]      = '0;
			pending_jobs[c]   = 0;
			head_slot[c]      = 0;
		end
		for (int g = 0; g < NGROUPS; g++)
			cores_cfg[g] = 1;
		arst_n      = 1'b0;
		req_valid   = 1'b0;
		operation   = OP_SUBMIT;
		group       = '0;
		job_latency = '0;
		start_delay = '0;
		job_tag     = '0;
		rsp_ready   = 1'b0;
		psel        = 1'b0;
		penable     = 1'b0;
		pwrite      = 1'b0;
		paddr       = '0;
		pwdata      = '0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_empty_groups();
		test_queue_full();
		test_pick_and_clear();
		test_random(4, 4, 4, 0, 0, 50);
		test_random(0, 7, 1, 72, 0, 50);
		test_random($urandom_range(4), $urandom_range(4), 4, 0, 72, 50);
		test_random(2, $urandom_range(7), 3, 26, 26, 50);
		drain();

		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
